### sv/jpg_pkg.sv
// ----------------------------------------------------------------------------
// jpg_pkg
// Shared constants, types and the microcode ROM of the Josephus
// permutation generator.
// ----------------------------------------------------------------------------
package jpg_pkg;

    localparam int MAX_PEOPLE = 1024;
    localparam int POS_W      = $clog2(MAX_PEOPLE);
    localparam int CNT_W      = 11;
    localparam int DIV_STEPS  = CNT_W;
    localparam int BIT_W      = $clog2(DIV_STEPS);
    localparam int UPC_W      = 4;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_PEOPLE);

    // register select is paddr[2]
    localparam logic REG_PEOPLE_COUNT = 1'b0;
    localparam logic REG_STEP_K       = 1'b1;

    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t U_WAIT      = 4'd0;
    localparam upc_t U_TEST      = 4'd1;
    localparam upc_t U_INIT      = 4'd2;
    localparam upc_t U_FILL      = 4'd3;
    localparam upc_t U_CHECK     = 4'd4;
    localparam upc_t U_DIV       = 4'd5;
    localparam upc_t U_SCAN_INIT = 4'd6;
    localparam upc_t U_SCAN      = 4'd7;
    localparam upc_t U_KILL      = 4'd8;
    localparam upc_t U_EMPTY     = 4'd9;
    localparam upc_t U_EMIT      = 4'd10;

    typedef enum logic [3:0] {
        OP_WAIT,
        OP_NOP,
        OP_INIT,
        OP_FILL,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_SCAN_INIT,
        OP_SCAN,
        OP_KILL,
        OP_EMPTY,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_REQ,
        C_NO_RESTART,
        C_FILL_DONE,
        C_EMPTY,
        C_DIV_DONE,
        C_HIT,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  adv;     // fall through to next step when cond is false
        upc_t  target;
    } ctrl_word_t;

    typedef struct packed {
        logic restart;
        logic fill_done;
        logic empty;
        logic div_done;
        logic hit;
    } dp_status_t;

    function automatic ctrl_word_t make_cw(input op_t op, input cond_t cond,
                                           input logic adv, input upc_t target);
        ctrl_word_t w;
        w.op     = op;
        w.cond   = cond;
        w.adv    = adv;
        w.target = target;
        return w;
    endfunction

    function automatic ctrl_word_t ucode_rom(input upc_t addr);
        ctrl_word_t w;
        unique case (addr)
            U_WAIT:      w = make_cw(OP_WAIT,      C_REQ,        1'b0, U_TEST);
            U_TEST:      w = make_cw(OP_NOP,       C_NO_RESTART, 1'b1, U_CHECK);
            U_INIT:      w = make_cw(OP_INIT,      C_ALWAYS,     1'b0, U_FILL);
            U_FILL:      w = make_cw(OP_FILL,      C_FILL_DONE,  1'b0, U_CHECK);
            U_CHECK:     w = make_cw(OP_DIV_INIT,  C_EMPTY,      1'b1, U_EMPTY);
            U_DIV:       w = make_cw(OP_DIV_STEP,  C_DIV_DONE,   1'b0, U_SCAN_INIT);
            U_SCAN_INIT: w = make_cw(OP_SCAN_INIT, C_ALWAYS,     1'b0, U_SCAN);
            U_SCAN:      w = make_cw(OP_SCAN,      C_HIT,        1'b0, U_KILL);
            U_KILL:      w = make_cw(OP_KILL,      C_ALWAYS,     1'b0, U_EMIT);
            U_EMPTY:     w = make_cw(OP_EMPTY,     C_ALWAYS,     1'b0, U_EMIT);
            U_EMIT:      w = make_cw(OP_EMIT,      C_OUT_FREE,   1'b0, U_WAIT);
            default:     w = make_cw(OP_WAIT,      C_ALWAYS,     1'b0, U_WAIT);
        endcase
        return w;
    endfunction

endpackage

### sv/jpg_useq.sv
// ----------------------------------------------------------------------------
// jpg_useq
// Step counter and microcode ROM; picks the next step from the control
// word's condition and jump target.
// ----------------------------------------------------------------------------
module jpg_useq
(
    input  logic                clk,
    input  logic                rst_n,
    input  jpg_pkg::dp_status_t st,
    input  logic                req,
    input  logic                out_free,
    output jpg_pkg::ctrl_word_t cw
);

    jpg_pkg::upc_t upc_reg;
    jpg_pkg::upc_t upc_next;
    logic          take;

    assign cw = jpg_pkg::ucode_rom(upc_reg);

    always_comb
    begin
        unique case (cw.cond)
            jpg_pkg::C_ALWAYS:     take = 1'b1;
            jpg_pkg::C_REQ:        take = req;
            jpg_pkg::C_NO_RESTART: take = !st.restart;
            jpg_pkg::C_FILL_DONE:  take = st.fill_done;
            jpg_pkg::C_EMPTY:      take = st.empty;
            jpg_pkg::C_DIV_DONE:   take = st.div_done;
            jpg_pkg::C_HIT:        take = st.hit;
            jpg_pkg::C_OUT_FREE:   take = out_free;
            default:               take = 1'b1;
        endcase
    end

    always_comb
    begin
        if (take)
        begin
            upc_next = cw.target;
        end
        else if (cw.adv)
        begin
            upc_next = upc_reg + jpg_pkg::upc_t'(1);
        end
        else
        begin
            upc_next = upc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= jpg_pkg::U_WAIT;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

### sv/jpg_datapath.sv
// ----------------------------------------------------------------------------
// jpg_datapath
// Liveness memory, circle counters, shift-subtract remainder unit and the
// live-member scan, all driven by the microcode control word.
// ----------------------------------------------------------------------------
module jpg_datapath
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  jpg_pkg::ctrl_word_t              cw,
    input  logic                             accept,
    input  logic                             in_restart,
    input  logic [jpg_pkg::CNT_W-1:0]        people_count,
    input  logic [jpg_pkg::CNT_W-1:0]        step_k,
    output jpg_pkg::dp_status_t              st,
    output logic [jpg_pkg::CNT_W-1:0]        res_person,
    output logic                             res_last,
    output logic                             res_none
);

    logic alive_mem [jpg_pkg::MAX_PEOPLE];

    logic                        restart_reg;
    logic [jpg_pkg::CNT_W-1:0]   remaining_reg;
    logic [jpg_pkg::POS_W-1:0]   cursor_reg;
    logic [jpg_pkg::POS_W-1:0]   fill_idx_reg;
    logic [jpg_pkg::CNT_W-1:0]   dvd_reg;
    logic [jpg_pkg::CNT_W-1:0]   rem_reg;
    logic [jpg_pkg::BIT_W-1:0]   bit_reg;
    logic [jpg_pkg::CNT_W-1:0]   need_reg;
    logic [jpg_pkg::POS_W-1:0]   pos_reg;
    logic [jpg_pkg::POS_W-1:0]   rd_pos_reg;
    logic                        rd_valid_reg;
    logic                        rd_data_reg;
    logic [jpg_pkg::CNT_W-1:0]   res_person_reg;
    logic                        res_last_reg;
    logic                        res_none_reg;

    logic [jpg_pkg::CNT_W-1:0]   k_eff;
    logic [jpg_pkg::CNT_W-1:0]   n_sat;
    logic [jpg_pkg::CNT_W:0]     trial;
    logic [jpg_pkg::CNT_W-1:0]   rem_step;
    logic                        hit;
    logic                        mem_we;
    logic [jpg_pkg::POS_W-1:0]   mem_waddr;
    logic                        mem_wdata;

    assign k_eff = (step_k == '0) ? jpg_pkg::CNT_W'(1) : step_k;
    assign n_sat = (people_count > jpg_pkg::MAX_COUNT) ? jpg_pkg::MAX_COUNT : people_count;

    // one restoring remainder step: shift in the next dividend bit
    assign trial    = {rem_reg, dvd_reg[jpg_pkg::CNT_W-1]};
    assign rem_step = (trial >= {1'b0, remaining_reg})
                    ? jpg_pkg::CNT_W'(trial - {1'b0, remaining_reg})
                    : trial[jpg_pkg::CNT_W-1:0];

    assign hit = rd_valid_reg && rd_data_reg && (need_reg == jpg_pkg::CNT_W'(1));

    assign mem_we    = (cw.op == jpg_pkg::OP_FILL) || (cw.op == jpg_pkg::OP_KILL);
    assign mem_waddr = (cw.op == jpg_pkg::OP_FILL) ? fill_idx_reg : rd_pos_reg;
    assign mem_wdata = (cw.op == jpg_pkg::OP_FILL)
                     && ({1'b0, fill_idx_reg} < remaining_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            alive_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= alive_mem[pos_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_reg    <= 1'b0;
            remaining_reg  <= '0;
            cursor_reg     <= '0;
            fill_idx_reg   <= '0;
            dvd_reg        <= '0;
            rem_reg        <= '0;
            bit_reg        <= '0;
            need_reg       <= '0;
            pos_reg        <= '0;
            rd_pos_reg     <= '0;
            rd_valid_reg   <= 1'b0;
            res_person_reg <= '0;
            res_last_reg   <= 1'b0;
            res_none_reg   <= 1'b0;
        end
        else
        begin
            unique case (cw.op)
                jpg_pkg::OP_WAIT:
                begin
                    if (accept)
                    begin
                        restart_reg <= in_restart;
                    end
                end
                jpg_pkg::OP_INIT:
                begin
                    remaining_reg <= n_sat;
                    cursor_reg    <= '0;
                    fill_idx_reg  <= '0;
                end
                jpg_pkg::OP_FILL:
                begin
                    fill_idx_reg <= fill_idx_reg + jpg_pkg::POS_W'(1);
                end
                jpg_pkg::OP_DIV_INIT:
                begin
                    rem_reg <= '0;
                    dvd_reg <= k_eff - jpg_pkg::CNT_W'(1);
                    bit_reg <= jpg_pkg::BIT_W'(jpg_pkg::DIV_STEPS - 1);
                end
                jpg_pkg::OP_DIV_STEP:
                begin
                    rem_reg <= rem_step;
                    dvd_reg <= {dvd_reg[jpg_pkg::CNT_W-2:0], 1'b0};
                    bit_reg <= bit_reg - jpg_pkg::BIT_W'(1);
                end
                jpg_pkg::OP_SCAN_INIT:
                begin
                    need_reg     <= rem_reg + jpg_pkg::CNT_W'(1);
                    pos_reg      <= cursor_reg;
                    rd_valid_reg <= 1'b0;
                end
                jpg_pkg::OP_SCAN:
                begin
                    pos_reg <= pos_reg + jpg_pkg::POS_W'(1);
                    // hold the read position on a hit so the kill step can use it
                    if (!hit)
                    begin
                        rd_pos_reg   <= pos_reg;
                        rd_valid_reg <= 1'b1;
                        if (rd_valid_reg && rd_data_reg)
                        begin
                            need_reg <= need_reg - jpg_pkg::CNT_W'(1);
                        end
                    end
                end
                jpg_pkg::OP_KILL:
                begin
                    remaining_reg  <= remaining_reg - jpg_pkg::CNT_W'(1);
                    cursor_reg     <= rd_pos_reg + jpg_pkg::POS_W'(1);
                    res_person_reg <= {1'b0, rd_pos_reg} + jpg_pkg::CNT_W'(1);
                    res_last_reg   <= (remaining_reg == jpg_pkg::CNT_W'(1));
                    res_none_reg   <= 1'b0;
                end
                jpg_pkg::OP_EMPTY:
                begin
                    res_person_reg <= '0;
                    res_last_reg   <= 1'b0;
                    res_none_reg   <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign st.restart   = restart_reg;
    assign st.fill_done = (fill_idx_reg == '1);
    assign st.empty     = (remaining_reg == '0);
    assign st.div_done  = (bit_reg == '0);
    assign st.hit       = hit;

    assign res_person = res_person_reg;
    assign res_last   = res_last_reg;
    assign res_none   = res_none_reg;

    a_need_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cw.op == jpg_pkg::OP_SCAN) |-> (need_reg != '0))
        else $error("scan running with zero count");

    a_remaining_bound: assert property (@(posedge clk) disable iff (!rst_n)
        remaining_reg <= jpg_pkg::MAX_COUNT)
        else $error("live count above circle capacity");

    a_kill_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cw.op == jpg_pkg::OP_KILL) |-> (remaining_reg != '0) && $past(hit))
        else $error("kill step without a live hit");

endmodule

### sv/josephus_permutation_generator_core.sv
// ----------------------------------------------------------------------------
// josephus_permutation_generator_core
// Josephus elimination order generator, one removed member per request.
// ----------------------------------------------------------------------------
// Usage:
//   Write people_count (0x0) and step_k (0x4) over APB while the block is
//   idle. Each request on s_axis carries restart in tdata[0]; a request with
//   restart set rebuilds a circle of people_count members first. Each
//   request yields one result on m_axis: tdata[10:0] the 1-based member
//   removed (0 if the circle was empty), tlast when that removal emptied the
//   circle, tuser when no member was left.
//   Flow: an accepted request runs the 11-step remainder unit, then a scan
//   that reads liveness entries one at a time to reach the kth live member,
//   as the 1024-entry liveness memory has a single read port. A restart
//   adds a rebuild sweep over all 1024 entries, one memory entry per cycle.
//   A request on an empty circle skips the remainder unit and the scan.
//   Reset leaves the circle empty: requests return none_left until a restart.
//   The result sits in an output register; the next request is taken while
//   it waits, and the sequencer holds its next result until m_axis drains.
// ----------------------------------------------------------------------------
module josephus_permutation_generator_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    // APB configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [jpg_pkg::ADDR_W-1:0]   paddr,
    input  logic [jpg_pkg::DATA_W-1:0]   pwdata,
    output logic [jpg_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    // request stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [0] restart, [7:1] zero
    // result stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [15:0]                  m_axis_tdata,   // [10:0] person, [15:11] zero
    output logic                         m_axis_tlast,   // is_last
    output logic                         m_axis_tuser    // none_left
);

    logic [jpg_pkg::CNT_W-1:0] people_count_reg;
    logic [jpg_pkg::CNT_W-1:0] step_k_reg;
    logic                      cfg_write;

    jpg_pkg::ctrl_word_t       cw;
    jpg_pkg::dp_status_t       st;
    logic                      accept;
    logic                      out_free;
    logic [jpg_pkg::CNT_W-1:0] res_person;
    logic                      res_last;
    logic                      res_none;

    logic                      out_valid_reg;
    logic [jpg_pkg::CNT_W-1:0] out_person_reg;
    logic                      out_last_reg;
    logic                      out_none_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            people_count_reg <= jpg_pkg::CNT_W'(1);
            step_k_reg       <= jpg_pkg::CNT_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                jpg_pkg::REG_PEOPLE_COUNT: people_count_reg <= pwdata[jpg_pkg::CNT_W-1:0];
                jpg_pkg::REG_STEP_K:       step_k_reg       <= pwdata[jpg_pkg::CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            jpg_pkg::REG_PEOPLE_COUNT:
                prdata = {{(jpg_pkg::DATA_W-jpg_pkg::CNT_W){1'b0}}, people_count_reg};
            jpg_pkg::REG_STEP_K:
                prdata = {{(jpg_pkg::DATA_W-jpg_pkg::CNT_W){1'b0}}, step_k_reg};
            default:
                prdata = '0;
        endcase
    end

    assign s_axis_tready = (cw.op == jpg_pkg::OP_WAIT);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    jpg_useq u_useq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .st       (st),
        .req      (s_axis_tvalid),
        .out_free (out_free),
        .cw       (cw)
    );

    jpg_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cw           (cw),
        .accept       (accept),
        .in_restart   (s_axis_tdata[0]),
        .people_count (people_count_reg),
        .step_k       (step_k_reg),
        .st           (st),
        .res_person   (res_person),
        .res_last     (res_last),
        .res_none     (res_none)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            out_person_reg <= '0;
            out_last_reg   <= 1'b0;
            out_none_reg   <= 1'b0;
        end
        else if ((cw.op == jpg_pkg::OP_EMIT) && out_free)
        begin
            out_valid_reg  <= 1'b1;
            out_person_reg <= res_person;
            out_last_reg   <= res_last;
            out_none_reg   <= res_none;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(16-jpg_pkg::CNT_W){1'b0}}, out_person_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_none_reg;

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (out_person_reg == '0) && !m_axis_tlast)
        else $error("empty-circle result carries a member");

    a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(cw.op == jpg_pkg::OP_EMIT))
        else $error("result register loaded outside the emit step");

    a_take_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (cw.op == jpg_pkg::OP_NOP))
        else $error("request taken but sequencer did not move to test step");

endmodule
